>>> hw/rtl/ddrs_pkg.sv
// Shared types and constants for the dual deque rotate/swap engine.
package ddrs_pkg;

    localparam int ACTION_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;
    localparam int FIELD_W   = 32;
    localparam int S_USER_W  = 8;
    localparam int M_USER_W  = 8;
    localparam int M_DATA_W  = 88;
    localparam int M_PAD_W   = M_DATA_W - 2 * COUNT_W - 2 * FIELD_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_ROTATE  = 3'd1,
        ACT_RROTATE = 3'd2,
        ACT_SWAP    = 3'd3,
        ACT_PUSH    = 3'd4
    } action_t;

    localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_APPEND = 4'd1,
        CMD_ROT1   = 4'd2,
        CMD_LOAD   = 4'd3,
        CMD_RROT1  = 4'd4,
        CMD_RROT2  = 4'd5,
        CMD_SWAP1  = 4'd6,
        CMD_SWAP2  = 4'd7,
        CMD_POP1   = 4'd8,
        CMD_PUSH   = 4'd9
    } deq_cmd_t;

    typedef struct packed {
        logic empty;
        logic few;
        logic full;
    } deq_flags_t;

endpackage

>>> hw/rtl/dual_deque_rotate_swap_engine_top.sv
// Top level: request decode, two-phase sequencer and result register over two deques.
//
// Each request applies one operation to deque A or B and returns one result with the
// status, both counts and both head values. Append, rejected or ignored requests and
// unused action codes go from acceptance straight to the result; rotate, reverse rotate,
// swap and push take a second phase first, because the new head (or the moved tail)
// must be fetched through the deque memory's registered read port before write-back.
// A new request is taken in the cycle the previous result is loaded into the output
// register, so single-phase requests run back to back while the result side keeps up.
// The element memories are not cleared after reset; only entries inside the count are read.
module dual_deque_rotate_swap_engine_top #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [7:0]  s_tuser,   // action[2:0], target[3], zero[7:4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // count_a[10:0], count_b[21:11], front_a[53:22],
                                   // front_b[85:54], zero[87:86]
    output logic [7:0]  m_tuser    // status[1:0], zero[7:2]
);

    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIN,
        ST_RESP
    } state_t;

    state_t                              state_reg, state_next;
    ddrs_pkg::deq_cmd_t                  ph2_a_reg, ph2_a_next;
    ddrs_pkg::deq_cmd_t                  ph2_b_reg, ph2_b_next;
    logic [ddrs_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [ddrs_pkg::M_DATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [ddrs_pkg::M_USER_W-1:0]       m_tuser_reg, m_tuser_next;

    ddrs_pkg::deq_cmd_t                  cmd_a, cmd_b;
    ddrs_pkg::deq_cmd_t                  d1, d2, s1, s2;
    logic [ddrs_pkg::STATUS_W-1:0]       dstat;
    logic [DATA_BITS-1:0]                wdata_a, wdata_b;
    logic [DATA_BITS-1:0]                front_a, front_b;
    logic [FW-1:0]                       fill_a, fill_b;
    ddrs_pkg::deq_flags_t                flags_a, flags_b;
    ddrs_pkg::deq_flags_t                dst_f, src_f;
    logic [DATA_BITS-1:0]                value_ext;
    logic [ddrs_pkg::ACTION_W-1:0]       act;
    logic                                tgt_b;
    logic                                out_free;
    logic                                accept;

    assign act       = s_tuser[ddrs_pkg::ACTION_W-1:0];
    assign tgt_b     = s_tuser[ddrs_pkg::ACTION_W];
    assign value_ext = DATA_BITS'($signed(s_tdata));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) || ((state_reg == ST_RESP) && out_free);
    assign accept    = s_tvalid && s_tready;
    assign dst_f     = tgt_b ? flags_b : flags_a;
    assign src_f     = tgt_b ? flags_a : flags_b;

    always_comb
    begin
        d1    = ddrs_pkg::CMD_NONE;
        d2    = ddrs_pkg::CMD_NONE;
        s1    = ddrs_pkg::CMD_NONE;
        s2    = ddrs_pkg::CMD_NONE;
        dstat = ddrs_pkg::STAT_DONE;
        unique case (act)
            ddrs_pkg::ACT_APPEND:
            begin
                if (dst_f.full)
                begin
                    dstat = ddrs_pkg::STAT_FULL;
                end
                else
                begin
                    d1 = ddrs_pkg::CMD_APPEND;
                end
            end
            ddrs_pkg::ACT_ROTATE:
            begin
                if (dst_f.few)
                begin
                    dstat = ddrs_pkg::STAT_FEW;
                end
                else
                begin
                    d1 = ddrs_pkg::CMD_ROT1;
                    d2 = ddrs_pkg::CMD_LOAD;
                end
            end
            ddrs_pkg::ACT_RROTATE:
            begin
                if (dst_f.few)
                begin
                    dstat = ddrs_pkg::STAT_FEW;
                end
                else
                begin
                    d1 = ddrs_pkg::CMD_RROT1;
                    d2 = ddrs_pkg::CMD_RROT2;
                end
            end
            ddrs_pkg::ACT_SWAP:
            begin
                if (dst_f.few)
                begin
                    dstat = ddrs_pkg::STAT_FEW;
                end
                else
                begin
                    d1 = ddrs_pkg::CMD_SWAP1;
                    d2 = ddrs_pkg::CMD_SWAP2;
                end
            end
            ddrs_pkg::ACT_PUSH:
            begin
                priority if (src_f.empty)
                begin
                    dstat = ddrs_pkg::STAT_FEW;
                end
                else if (dst_f.full)
                begin
                    dstat = ddrs_pkg::STAT_FULL;
                end
                else
                begin
                    d1 = ddrs_pkg::CMD_PUSH;
                    s1 = ddrs_pkg::CMD_POP1;
                    s2 = ddrs_pkg::CMD_LOAD;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cmd_a = ddrs_pkg::CMD_NONE;
        cmd_b = ddrs_pkg::CMD_NONE;
        if (state_reg == ST_FIN)
        begin
            cmd_a = ph2_a_reg;
            cmd_b = ph2_b_reg;
        end
        else if (accept)
        begin
            cmd_a = tgt_b ? s1 : d1;
            cmd_b = tgt_b ? d1 : s1;
        end
    end

    assign wdata_a = (act == ddrs_pkg::ACT_PUSH) ? front_b : value_ext;
    assign wdata_b = (act == ddrs_pkg::ACT_PUSH) ? front_a : value_ext;

    always_comb
    begin
        state_next    = state_reg;
        ph2_a_next    = ph2_a_reg;
        ph2_b_next    = ph2_b_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
            ST_FIN:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{ddrs_pkg::M_PAD_W{1'b0}},
                                     ddrs_pkg::FIELD_W'(front_b),
                                     ddrs_pkg::FIELD_W'(front_a),
                                     ddrs_pkg::COUNT_W'(fill_b),
                                     ddrs_pkg::COUNT_W'(fill_a)};
                    m_tuser_next  = ddrs_pkg::M_USER_W'(status_reg);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (accept)
        begin
            status_next = dstat;
            ph2_a_next  = tgt_b ? s2 : d2;
            ph2_b_next  = tgt_b ? d2 : s2;
            if ((d2 != ddrs_pkg::CMD_NONE) || (s2 != ddrs_pkg::CMD_NONE))
            begin
                state_next = ST_FIN;
            end
            else
            begin
                state_next = ST_RESP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ph2_a_reg    <= ddrs_pkg::CMD_NONE;
            ph2_b_reg    <= ddrs_pkg::CMD_NONE;
            status_reg   <= ddrs_pkg::STAT_DONE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ph2_a_reg    <= ph2_a_next;
            ph2_b_reg    <= ph2_b_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    ddrs_deque #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_deq_a (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_a),
        .wdata (wdata_a),
        .front (front_a),
        .fill  (fill_a),
        .flags (flags_a)
    );

    ddrs_deque #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_deq_b (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_b),
        .wdata (wdata_b),
        .front (front_b),
        .fill  (fill_b),
        .flags (flags_b)
    );

endmodule

>>> hw/rtl/ddrs_deque.sv
// One ring-buffer deque: element memory, head pointer, count and cached head value.
module ddrs_deque #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 32,
    localparam int FW       = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ddrs_pkg::deq_cmd_t    cmd,
    input  logic [DATA_BITS-1:0]  wdata,
    output logic [DATA_BITS-1:0]  front,
    output logic [FW-1:0]         fill,
    output ddrs_pkg::deq_flags_t  flags
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = FW + 1;

    logic [DATA_BITS-1:0] ring [DEPTH];
    logic [DATA_BITS-1:0] rd_reg;
    logic [DATA_BITS-1:0] front_reg, front_next;
    logic [AW-1:0]        start_reg, start_next;
    logic [FW-1:0]        fill_reg, fill_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [DATA_BITS-1:0] wd;
    logic [SW-1:0]        tail_sum;
    logic [AW-1:0]        tail;
    logic [AW-1:0]        last;
    logic [AW-1:0]        nxt;
    logic [AW-1:0]        prv;

    assign tail_sum = SW'(start_reg) + SW'(fill_reg);
    assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign last     = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);
    assign nxt      = (start_reg == AW'(DEPTH - 1)) ? '0 : start_reg + AW'(1);
    assign prv      = (start_reg == '0) ? AW'(DEPTH - 1) : start_reg - AW'(1);

    always_comb
    begin
        we         = 1'b0;
        waddr      = tail;
        wd         = wdata;
        raddr      = nxt;
        start_next = start_reg;
        fill_next  = fill_reg;
        front_next = front_reg;
        unique case (cmd)
            ddrs_pkg::CMD_NONE:
            begin
            end
            ddrs_pkg::CMD_APPEND:
            begin
                we        = 1'b1;
                fill_next = fill_reg + FW'(1);
                if (fill_reg == '0)
                begin
                    front_next = wdata;
                end
            end
            ddrs_pkg::CMD_ROT1:
            begin
                we         = 1'b1;
                wd         = front_reg;
                start_next = nxt;
            end
            ddrs_pkg::CMD_LOAD:
            begin
                front_next = rd_reg;
            end
            ddrs_pkg::CMD_RROT1:
            begin
                raddr = last;
            end
            ddrs_pkg::CMD_RROT2:
            begin
                we         = 1'b1;
                waddr      = prv;
                wd         = rd_reg;
                start_next = prv;
                front_next = rd_reg;
            end
            ddrs_pkg::CMD_SWAP1:
            begin
                // read-before-write: old second element lands in rd_reg
                we    = 1'b1;
                waddr = nxt;
                wd    = front_reg;
            end
            ddrs_pkg::CMD_SWAP2:
            begin
                we         = 1'b1;
                waddr      = start_reg;
                wd         = rd_reg;
                front_next = rd_reg;
            end
            ddrs_pkg::CMD_POP1:
            begin
                start_next = nxt;
                fill_next  = fill_reg - FW'(1);
            end
            ddrs_pkg::CMD_PUSH:
            begin
                we         = 1'b1;
                waddr      = prv;
                start_next = prv;
                fill_next  = fill_reg + FW'(1);
                front_next = wdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring[waddr] <= wd;
        end
        rd_reg    <= ring[raddr];
        front_reg <= front_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            start_reg <= start_next;
            fill_reg  <= fill_next;
        end
    end

    assign front       = (fill_reg == '0) ? '0 : front_reg;
    assign fill        = fill_reg;
    assign flags.empty = (fill_reg == '0);
    assign flags.few   = (fill_reg < FW'(2));
    assign flags.full  = (fill_reg == FW'(DEPTH));

endmodule

>>> tb/dual_deque_rotate_swap_engine_top_test.sv
// Self-checking stream testbench for the dual deque rotate/swap engine.
module dual_deque_rotate_swap_engine_top_test;

    localparam int DEPTH       = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int N_DIRECTED  = 25;

    localparam logic TGT_A = 1'b0;
    localparam logic TGT_B = 1'b1;

    // action codes the block decodes as no-ops
    localparam logic [ddrs_pkg::ACTION_W-1:0] ACT_NOP_FIRST = 3'd5;
    localparam logic [ddrs_pkg::ACTION_W-1:0] ACT_NOP_MID   = 3'd6;
    localparam logic [ddrs_pkg::ACTION_W-1:0] ACT_NOP_LAST  = 3'd7;

    typedef struct packed {
        logic [ddrs_pkg::STATUS_W-1:0] status;
        logic [ddrs_pkg::COUNT_W-1:0]  count_a;
        logic [ddrs_pkg::COUNT_W-1:0]  count_b;
        logic [31:0]                   front_a;
        logic [31:0]                   front_b;
    } deque_view_t;

    typedef struct packed {
        logic [ddrs_pkg::ACTION_W-1:0] act;
        logic                          tgt;
        logic [31:0]                   val;
        logic                          typed;
        deque_view_t                   view;
    } request_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [7:0]  m_tuser;

    // predicted contents of both deques
    logic [31:0] deque_mem [2][DEPTH];
    int          deque_head [2];
    int          deque_fill [2];

    deque_view_t awaited_views [$];

    int  err_count     = 0;
    int  results_seen  = 0;
    int  requests_sent = 0;
    int  full_hits     = 0;
    int  few_hits      = 0;
    int  calm_left     = 0;
    int  cycle_cnt     = 0;
    logic fill_side;

    request_row_t directed_rows [N_DIRECTED] = '{
        '{ddrs_pkg::ACT_ROTATE,  TGT_A, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_FEW, 11'd0, 11'd0, 32'h0, 32'h0}},
        '{ddrs_pkg::ACT_RROTATE, TGT_B, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_FEW, 11'd0, 11'd0, 32'h0, 32'h0}},
        '{ddrs_pkg::ACT_SWAP,    TGT_A, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_FEW, 11'd0, 11'd0, 32'h0, 32'h0}},
        '{ddrs_pkg::ACT_PUSH,    TGT_A, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_FEW, 11'd0, 11'd0, 32'h0, 32'h0}},
        '{ddrs_pkg::ACT_PUSH,    TGT_B, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_FEW, 11'd0, 11'd0, 32'h0, 32'h0}},
        '{ddrs_pkg::ACT_APPEND, TGT_A, 32'h7fffffff, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd1, 11'd0, 32'h7fffffff, 32'h0}},
        '{ddrs_pkg::ACT_APPEND, TGT_B, 32'h80000000, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd1, 11'd1, 32'h7fffffff, 32'h80000000}},
        '{ddrs_pkg::ACT_SWAP, TGT_B, 32'hffffffff, 1'b1,
          '{ddrs_pkg::STAT_FEW, 11'd1, 11'd1, 32'h7fffffff, 32'h80000000}},
        '{ddrs_pkg::ACT_PUSH, TGT_B, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd0, 11'd2, 32'h0, 32'h7fffffff}},
        '{ddrs_pkg::ACT_PUSH, TGT_A, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd1, 11'd1, 32'h7fffffff, 32'h80000000}},
        '{ddrs_pkg::ACT_APPEND, TGT_A, 32'hffffffff, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd2, 11'd1, 32'h7fffffff, 32'h80000000}},
        '{ddrs_pkg::ACT_APPEND, TGT_A, 32'h00000000, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd3, 11'd1, 32'h7fffffff, 32'h80000000}},
        '{ddrs_pkg::ACT_SWAP, TGT_A, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd3, 11'd1, 32'hffffffff, 32'h80000000}},
        '{ddrs_pkg::ACT_ROTATE, TGT_A, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd3, 11'd1, 32'h7fffffff, 32'h80000000}},
        '{ddrs_pkg::ACT_RROTATE, TGT_A, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd3, 11'd1, 32'hffffffff, 32'h80000000}},
        '{ACT_NOP_FIRST, TGT_A, 32'h12345678, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd3, 11'd1, 32'hffffffff, 32'h80000000}},
        '{ACT_NOP_MID, TGT_B, 32'h0, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd3, 11'd1, 32'hffffffff, 32'h80000000}},
        '{ACT_NOP_LAST, TGT_B, 32'haaaaaaaa, 1'b1,
          '{ddrs_pkg::STAT_DONE, 11'd3, 11'd1, 32'hffffffff, 32'h80000000}},
        '{ddrs_pkg::ACT_APPEND,  TGT_B, 32'h55555555, 1'b0, '0},
        '{ddrs_pkg::ACT_ROTATE,  TGT_B, 32'h0,        1'b0, '0},
        '{ddrs_pkg::ACT_RROTATE, TGT_B, 32'h0,        1'b0, '0},
        '{ddrs_pkg::ACT_SWAP,    TGT_B, 32'h0,        1'b0, '0},
        '{ddrs_pkg::ACT_PUSH,    TGT_A, 32'h0,        1'b0, '0},
        '{ddrs_pkg::ACT_PUSH,    TGT_B, 32'h0,        1'b0, '0},
        '{ddrs_pkg::ACT_APPEND,  TGT_A, 32'h00000001, 1'b0, '0}
    };

    dual_deque_rotate_swap_engine_top #(
        .DEPTH     (DEPTH),
        .DATA_BITS (32)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic deque_view_t apply_deque_op(input logic [ddrs_pkg::ACTION_W-1:0] act,
                                                   input logic tgt, input logic [31:0] val);
        int          d;
        int          o;
        int          last;
        int          second;
        logic [31:0] moved;
        deque_view_t view;
        d = tgt;
        o = !tgt;
        view.status = ddrs_pkg::STAT_DONE;
        case (act)
            ddrs_pkg::ACT_APPEND:
                if (deque_fill[d] >= DEPTH)
                    view.status = ddrs_pkg::STAT_FULL;
                else
                begin
                    deque_mem[d][(deque_head[d] + deque_fill[d]) % DEPTH] = val;
                    deque_fill[d]++;
                end
            ddrs_pkg::ACT_ROTATE:
                if (deque_fill[d] < 2)
                    view.status = ddrs_pkg::STAT_FEW;
                else
                begin
                    deque_mem[d][(deque_head[d] + deque_fill[d]) % DEPTH] =
                        deque_mem[d][deque_head[d]];
                    deque_head[d] = (deque_head[d] + 1) % DEPTH;
                end
            ddrs_pkg::ACT_RROTATE:
                if (deque_fill[d] < 2)
                    view.status = ddrs_pkg::STAT_FEW;
                else
                begin
                    last = (deque_head[d] + deque_fill[d] - 1) % DEPTH;
                    deque_head[d] = (deque_head[d] + DEPTH - 1) % DEPTH;
                    deque_mem[d][deque_head[d]] = deque_mem[d][last];
                end
            ddrs_pkg::ACT_SWAP:
                if (deque_fill[d] < 2)
                    view.status = ddrs_pkg::STAT_FEW;
                else
                begin
                    second = (deque_head[d] + 1) % DEPTH;
                    moved = deque_mem[d][deque_head[d]];
                    deque_mem[d][deque_head[d]] = deque_mem[d][second];
                    deque_mem[d][second] = moved;
                end
            ddrs_pkg::ACT_PUSH:
                if (deque_fill[o] == 0)
                    view.status = ddrs_pkg::STAT_FEW;
                else if (deque_fill[d] >= DEPTH)
                    view.status = ddrs_pkg::STAT_FULL;
                else
                begin
                    moved = deque_mem[o][deque_head[o]];
                    deque_head[o] = (deque_head[o] + 1) % DEPTH;
                    deque_fill[o]--;
                    deque_head[d] = (deque_head[d] + DEPTH - 1) % DEPTH;
                    deque_mem[d][deque_head[d]] = moved;
                    deque_fill[d]++;
                end
            default:
                view.status = ddrs_pkg::STAT_DONE;
        endcase
        view.count_a = ddrs_pkg::COUNT_W'(deque_fill[0]);
        view.count_b = ddrs_pkg::COUNT_W'(deque_fill[1]);
        view.front_a = deque_fill[0] == 0 ? 32'h0 : deque_mem[0][deque_head[0]];
        view.front_b = deque_fill[1] == 0 ? 32'h0 : deque_mem[1][deque_head[1]];
        return view;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] random_value();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 32'h80000000;
        else if (r < 6)
            return 32'h7fffffff;
        else if (r < 9)
            return 32'hffffffff;
        else if (r < 12)
            return 32'h00000000;
        else
            return $urandom();
    endfunction

    task automatic send_request(input logic [ddrs_pkg::ACTION_W-1:0] act, input logic tgt,
                                input logic [31:0] val, input logic typed,
                                input deque_view_t typed_view);
        int          gap;
        deque_view_t predicted;
        gap = calm_left > 0 ? 0 : pick_gap();
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(99) < 3)
            calm_left = $urandom_range(20, 80);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {4'b0000, tgt, act};
        s_tdata  <= val;
        do @(posedge clk); while (!s_tready);
        predicted = apply_deque_op(act, tgt, val);
        if (predicted.status == ddrs_pkg::STAT_FULL)
            full_hits++;
        if (predicted.status == ddrs_pkg::STAT_FEW)
            few_hits++;
        awaited_views.push_back(typed ? typed_view : predicted);
        requests_sent++;
    endtask

    task automatic send_random(input logic [ddrs_pkg::ACTION_W-1:0] act, input logic tgt);
        send_request(act, tgt, random_value(), 1'b0, '0);
    endtask

    // mostly appends into one deque, with rotations, swaps and pushes and a trickle through the other
    task automatic grow_request(input logic side);
        int r;
        r = $urandom_range(99);
        if (r < 70)
            send_random(ddrs_pkg::ACT_APPEND, side);
        else if (r < 77)
            send_random(ddrs_pkg::ACT_ROTATE, side);
        else if (r < 83)
            send_random(ddrs_pkg::ACT_RROTATE, side);
        else if (r < 89)
            send_random(ddrs_pkg::ACT_SWAP, side);
        else if (r < 93)
            send_random(ddrs_pkg::ACT_PUSH, side);
        else if (r < 97)
            send_random(ddrs_pkg::ACT_APPEND, !side);
        else
            send_random(ddrs_pkg::ACTION_W'($urandom_range(ddrs_pkg::ACT_ROTATE,
                                                           ddrs_pkg::ACT_SWAP)), !side);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        deque_view_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (awaited_views.size() == 0)
            begin
                $error("result with no request outstanding");
                err_count++;
            end
            else
            begin
                want = awaited_views.pop_front();
                check_field("status",  want.status,  m_tuser[1:0]);
                check_field("count_a", want.count_a, m_tdata[10:0]);
                check_field("count_b", want.count_b, m_tdata[21:11]);
                check_field("front_a", want.front_a, m_tdata[53:22]);
                check_field("front_b", want.front_b, m_tdata[85:54]);
            end
        end
    end

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin
        int  off;
        int  burst;
        bit  held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            off = pick_gap();
            if (!held && results_seen >= 200)
            begin
                off += HOLD_CYCLES;
                held = 1'b1;
            end
            if (off > 0)
            begin
                m_tready <= 1'b0;
                repeat (off) @(posedge clk);
            end
            m_tready <= 1'b1;
            burst = ($urandom_range(99) < 15) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 8);
            repeat (burst) @(posedge clk);
        end
    end

    initial
    begin
        int                            r;
        int                            mix_done;
        logic [ddrs_pkg::ACTION_W-1:0] act;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].act, directed_rows[i].tgt, directed_rows[i].val,
                         directed_rows[i].typed, directed_rows[i].view);

        fill_side = logic'($urandom_range(1));
        while (deque_fill[fill_side] < DEPTH)
            grow_request(fill_side);

        // hammer the full deque; the other one is kept non-empty for the push case
        send_random(ddrs_pkg::ACT_APPEND, !fill_side);
        repeat (12)
            send_random(ddrs_pkg::ACTION_W'($urandom_range(ddrs_pkg::ACT_APPEND,
                                                           ddrs_pkg::ACT_PUSH)), fill_side);

        mix_done = 0;
        while (mix_done < 250)
        begin
            r = $urandom_range(99);
            if (r < 4)
                act = ddrs_pkg::ACTION_W'($urandom_range(ACT_NOP_FIRST, ACT_NOP_LAST));
            else
                act = ddrs_pkg::ACTION_W'($urandom_range(ddrs_pkg::ACT_APPEND,
                                                         ddrs_pkg::ACT_PUSH));
            if (r >= 4 && r < 30)
                send_random(ddrs_pkg::ACT_PUSH, !fill_side);
            else
                send_random(act, logic'($urandom_range(1)));
            if (r >= 4)
                mix_done++;
        end

        s_tvalid <= 1'b0;
        while (awaited_views.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d requests (%0d directed), %0d results compared.",
                 requests_sent, N_DIRECTED, results_seen);
        $display("Deque %s filled to %0d; %0d full rejections, %0d too-few or empty cases.",
                 fill_side ? "B" : "A", DEPTH, full_hits, few_hits);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
